/* rtl/core/mmix_pkg.sv */
// mmix_pkg: shared types, constants and the sign table of the motor mixer
// no dependencies; imported by mmix_lane, multirotor_motor_mixer_unit and tb_top
`timescale 1ns / 1ps

package mmix_pkg;

  // output count of this build and of the result item
  localparam int OUTPUTS = 8;
  localparam int NREFS   = 8;

  // arithmetic widths
  localparam int CMD_W   = 16;
  localparam int TS_W    = 32;  // thrust times Q1.15 factor
  localparam int SUM_W   = 37;  // exact sum at 2^-19 scale
  localparam int FRAC_SH = 19;
  localparam int CMD_SH  = 15;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TYPE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_LOW    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_HIGH   = 2'd3;

  // frame type codes
  localparam logic [1:0] FRAME_X    = 2'd0;
  localparam logic [1:0] FRAME_PLUS = 2'd1;
  localparam logic [1:0] FRAME_TILT = 2'd2;

  // sign table indexes
  localparam int TBL_W = 3;
  localparam logic [TBL_W-1:0] TBL_X4    = 3'd0;
  localparam logic [TBL_W-1:0] TBL_X6    = 3'd1;
  localparam logic [TBL_W-1:0] TBL_X8    = 3'd2;
  localparam logic [TBL_W-1:0] TBL_PLUS4 = 3'd3;
  localparam logic [TBL_W-1:0] TBL_PLUS6 = 3'd4;
  localparam logic [TBL_W-1:0] TBL_PLUS8 = 3'd5;
  localparam logic [TBL_W-1:0] TBL_TILT  = 3'd6;

  // coefficient codes
  localparam logic signed [1:0] CP = 2'sb01;
  localparam logic signed [1:0] CN = 2'sb11;
  localparam logic signed [1:0] CZ = 2'sb00;

  typedef struct packed {
    logic signed [1:0] ct;
    logic signed [1:0] cr;
    logic signed [1:0] cp;
    logic signed [1:0] cy;
  } coef_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] thrust;
    logic signed [CMD_W-1:0] roll_cmd;
    logic signed [CMD_W-1:0] pitch_cmd;
    logic signed [CMD_W-1:0] yaw_cmd;
    logic                    landing;
    logic [15:0]             landing_factor;
  } cmd_item_t;

  typedef struct packed {
    logic signed [15:0] ref0;
    logic signed [15:0] ref1;
    logic signed [15:0] ref2;
    logic signed [15:0] ref3;
    logic signed [15:0] ref4;
    logic signed [15:0] ref5;
    logic signed [15:0] ref6;
    logic signed [15:0] ref7;
    logic               valid_res;
  } mix_item_t;

  // per output {thrust, roll, pitch, yaw} signs, one row per frame layout
  localparam coef_t MIX_TABLE [0:6][0:7] = '{
    '{ '{CP,CN,CN,CN}, '{CP,CN,CP,CP}, '{CP,CP,CP,CN}, '{CP,CP,CN,CP},
       '{CZ,CZ,CZ,CZ}, '{CZ,CZ,CZ,CZ}, '{CZ,CZ,CZ,CZ}, '{CZ,CZ,CZ,CZ} },
    '{ '{CP,CN,CN,CN}, '{CP,CN,CZ,CP}, '{CP,CN,CP,CN}, '{CP,CP,CP,CP},
       '{CP,CP,CZ,CN}, '{CP,CP,CN,CP}, '{CZ,CZ,CZ,CZ}, '{CZ,CZ,CZ,CZ} },
    '{ '{CP,CN,CN,CN}, '{CP,CN,CN,CP}, '{CP,CN,CP,CN}, '{CP,CN,CP,CP},
       '{CP,CP,CP,CN}, '{CP,CP,CP,CP}, '{CP,CP,CN,CN}, '{CP,CP,CN,CP} },
    '{ '{CP,CZ,CN,CN}, '{CP,CN,CZ,CP}, '{CP,CP,CZ,CN}, '{CP,CZ,CP,CP},
       '{CZ,CZ,CZ,CZ}, '{CZ,CZ,CZ,CZ}, '{CZ,CZ,CZ,CZ}, '{CZ,CZ,CZ,CZ} },
    '{ '{CP,CZ,CN,CN}, '{CP,CN,CN,CP}, '{CP,CN,CP,CN}, '{CP,CZ,CP,CP},
       '{CP,CP,CP,CN}, '{CP,CP,CN,CP}, '{CZ,CZ,CZ,CZ}, '{CZ,CZ,CZ,CZ} },
    '{ '{CP,CZ,CN,CN}, '{CP,CN,CN,CP}, '{CP,CN,CZ,CN}, '{CP,CN,CP,CP},
       '{CP,CZ,CP,CN}, '{CP,CP,CP,CP}, '{CP,CP,CZ,CN}, '{CP,CP,CN,CP} },
    '{ '{CP,CN,CZ,CZ}, '{CP,CN,CZ,CZ}, '{CP,CP,CZ,CZ}, '{CP,CP,CZ,CZ},
       '{CZ,CZ,CN,CP}, '{CZ,CZ,CP,CP}, '{CZ,CZ,CZ,CZ}, '{CZ,CZ,CZ,CZ} }
  };

endpackage

/* rtl/core/multirotor_motor_mixer_unit.sv */
// multirotor_motor_mixer_unit: top level of the motor mixing matrix
// depends on mmix_pkg and mmix_lane
`timescale 1ns / 1ps

// channel   signals                           role
// cmd       cmd_valid cmd_ready cmd            thrust/attitude command items
// mix       mix_valid mix_ready mix            held output references
// cfg       cfg_valid cfg_ready cfg_index/data register writes, always ready
//
// The thrust product is registered on acceptance, the lane sums and
// saturation feed the result register. One item per cycle is sustained while
// mix_ready stays high.
// The result register doubles as the held reference store, so each item sees
// the values left by the one before. A stalled result blocks the input stage
// only once that stage is also full. Reset clears the held references and
// loads the register defaults.

module multirotor_motor_mixer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  mmix_pkg::cmd_item_t               cmd,
  output logic                              mix_valid,
  input  logic                              mix_ready,
  output mmix_pkg::mix_item_t               mix,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mmix_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [63:0]                       cfg_data
);
  import mmix_pkg::*;

  // configuration registers
  logic [1:0]   frame_type;
  logic [3:0]   motor_count;
  logic [63:0]  idle_low;
  logic [63:0]  idle_high;
  logic [127:0] idle_all;

  // input stage
  logic                    s1_valid;
  logic signed [TS_W-1:0]  s1_thrust;
  logic signed [CMD_W-1:0] s1_roll;
  logic signed [CMD_W-1:0] s1_pitch;
  logic signed [CMD_W-1:0] s1_yaw;
  logic [16:0]             factor;
  logic signed [TS_W:0]    product;

  // result stage, also the held references
  logic                    out_valid;
  logic signed [15:0]      held [NREFS];
  logic                    held_res;
  logic signed [15:0]      lane_ref [NREFS];

  logic                    advance;
  logic [TBL_W-1:0]        tbl_sel;
  logic                    tbl_ok;
  logic [3:0]              rows;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || mix_ready);
  assign cmd_ready = !s1_valid || advance;
  assign mix_valid = out_valid;
  assign idle_all  = {idle_high, idle_low};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_type  <= FRAME_X;
      motor_count <= 4'd4;
      idle_low    <= '0;
      idle_high   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_TYPE:  frame_type  <= cfg_data[1:0];
        REG_MOTOR_COUNT: motor_count <= cfg_data[3:0];
        REG_IDLE_LOW:    idle_low    <= cfg_data;
        REG_IDLE_HIGH:   idle_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  // landing scale of thrust, factor one when not landing
  assign factor  = cmd.landing ? {1'b0, cmd.landing_factor} : 17'd32768;
  assign product = (TS_W+1)'(cmd.thrust) * (TS_W+1)'($signed(factor));

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      s1_thrust <= product[TS_W-1:0];
      s1_roll   <= cmd.roll_cmd;
      s1_pitch  <= cmd.pitch_cmd;
      s1_yaw    <= cmd.yaw_cmd;
    end
  end

  // frame layout select
  always_comb begin
    tbl_sel = TBL_X4;
    tbl_ok  = 1'b0;
    rows    = 4'd0;
    case (frame_type)
      FRAME_TILT: begin
        tbl_sel = TBL_TILT;
        tbl_ok  = 1'b1;
        rows    = 4'd6;
      end
      FRAME_X, FRAME_PLUS: begin
        case (motor_count)
          4'd4: begin
            tbl_sel = (frame_type == FRAME_X) ? TBL_X4 : TBL_PLUS4;
            tbl_ok  = 1'b1;
            rows    = 4'd4;
          end
          4'd6: begin
            tbl_sel = (frame_type == FRAME_X) ? TBL_X6 : TBL_PLUS6;
            tbl_ok  = 1'b1;
            rows    = 4'd6;
          end
          4'd8: begin
            tbl_sel = (frame_type == FRAME_X) ? TBL_X8 : TBL_PLUS8;
            tbl_ok  = 1'b1;
            rows    = 4'd8;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (32'(rows) > OUTPUTS) begin
      tbl_ok = 1'b0;
    end
  end

  // one lane per output
  for (genvar k = 0; k < NREFS; k++) begin : g_lane
    if (k < OUTPUTS) begin : g_used
      mmix_lane u_lane (
        .thrust_scaled (s1_thrust),
        .roll_cmd      (s1_roll),
        .pitch_cmd     (s1_pitch),
        .yaw_cmd       (s1_yaw),
        .idle          (idle_all[16*k +: 16]),
        .coef          (MIX_TABLE[tbl_sel][k]),
        .ref_val       (lane_ref[k])
      );
    end else begin : g_unused
      assign lane_ref[k] = '0;
    end
  end

  // result register, rows outside the frame keep their held values
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_res  <= 1'b0;
      for (int k = 0; k < NREFS; k++) begin
        held[k] <= '0;
      end
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        held_res  <= tbl_ok;
        for (int k = 0; k < NREFS; k++) begin
          if (tbl_ok && (k < 32'(rows)) && (k < OUTPUTS)) begin
            held[k] <= lane_ref[k];
          end
        end
      end else if (mix_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign mix.ref0      = held[0];
  assign mix.ref1      = held[1];
  assign mix.ref2      = held[2];
  assign mix.ref3      = held[3];
  assign mix.ref4      = held[4];
  assign mix.ref5      = held[5];
  assign mix.ref6      = held[6];
  assign mix.ref7      = held[7];
  assign mix.valid_res = held_res;

endmodule

/* rtl/core/mmix_lane.sv */
// mmix_lane: one output of the mixer, signed sum, truncation and saturation
// depends on mmix_pkg
`timescale 1ns / 1ps

module mmix_lane (
  input  logic signed [mmix_pkg::TS_W-1:0]  thrust_scaled,
  input  logic signed [mmix_pkg::CMD_W-1:0] roll_cmd,
  input  logic signed [mmix_pkg::CMD_W-1:0] pitch_cmd,
  input  logic signed [mmix_pkg::CMD_W-1:0] yaw_cmd,
  input  logic signed [15:0]                idle,
  input  mmix_pkg::coef_t                   coef,
  output logic signed [15:0]                ref_val
);
  import mmix_pkg::*;

  localparam int ATT_W = CMD_W + 2;
  localparam int Q_W   = SUM_W - FRAC_SH;

  logic signed [TS_W-1:0]  t_term;
  logic signed [ATT_W-1:0] r_term;
  logic signed [ATT_W-1:0] p_term;
  logic signed [ATT_W-1:0] y_term;
  logic signed [ATT_W-1:0] att_sum;
  logic signed [SUM_W-1:0] sum;
  logic signed [Q_W-1:0]   q_floor;
  logic signed [Q_W-1:0]   q_trunc;

  // apply the table signs
  always_comb begin
    case (coef.ct)
      CP:      t_term = thrust_scaled;
      CN:      t_term = -thrust_scaled;
      default: t_term = '0;
    endcase
    case (coef.cr)
      CP:      r_term = ATT_W'(roll_cmd);
      CN:      r_term = -ATT_W'(roll_cmd);
      default: r_term = '0;
    endcase
    case (coef.cp)
      CP:      p_term = ATT_W'(pitch_cmd);
      CN:      p_term = -ATT_W'(pitch_cmd);
      default: p_term = '0;
    endcase
    case (coef.cy)
      CP:      y_term = ATT_W'(yaw_cmd);
      CN:      y_term = -ATT_W'(yaw_cmd);
      default: y_term = '0;
    endcase
  end

  // exact sum at 2^-19 scale; thrust times -1 of the most negative value
  // cannot occur since the product never reaches -2^31
  assign att_sum = r_term + p_term + y_term;
  assign sum = SUM_W'(t_term)
             + (SUM_W'(att_sum) <<< CMD_SH)
             + (SUM_W'(idle) <<< FRAC_SH);

  // truncate toward zero
  assign q_floor = sum[SUM_W-1:FRAC_SH];
  assign q_trunc = (sum[SUM_W-1] && (sum[FRAC_SH-1:0] != '0)) ?
                   q_floor + Q_W'(1) : q_floor;

  // saturate to signed 16 bits
  always_comb begin
    if (q_trunc > Q_W'(32767)) begin
      ref_val = 16'sh7fff;
    end else if (q_trunc < -Q_W'(32768)) begin
      ref_val = 16'sh8000;
    end else begin
      ref_val = q_trunc[15:0];
    end
  end

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench of multirotor_motor_mixer_unit
// depends on mmix_pkg and the mixer RTL; predicts every result item in place
`timescale 1ns / 1ps

module tb_top;
  import mmix_pkg::*;

  localparam int          RANDOM_ITEMS = 1750;
  localparam int          STALL_LIMIT  = 500;   // cycles with no handshake at all
  localparam int          SETTLE       = 6;
  localparam int          REPORT_CAP   = 200;
  localparam logic [1:0]  FRAME_NONE   = 2'd3;
  localparam longint      CMD_SCALE    = 64'sd32768;
  localparam longint      SUM_SCALE    = 64'sd524288;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_ready;
  cmd_item_t              cmd = '0;
  logic                   mix_valid;
  logic                   mix_ready = 1'b0;
  mix_item_t              mix;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]            cfg_data = '0;

  multirotor_motor_mixer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .mix_valid (mix_valid),
    .mix_ready (mix_ready),
    .mix       (mix),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // {thrust, roll, pitch, yaw} signs per output, one row per layout
  int mix_signs [7][8][4] = '{
    '{ '{1,-1,-1,-1}, '{1,-1,1,1}, '{1,1,1,-1}, '{1,1,-1,1},
       '{0,0,0,0}, '{0,0,0,0}, '{0,0,0,0}, '{0,0,0,0} },
    '{ '{1,-1,-1,-1}, '{1,-1,0,1}, '{1,-1,1,-1}, '{1,1,1,1},
       '{1,1,0,-1}, '{1,1,-1,1}, '{0,0,0,0}, '{0,0,0,0} },
    '{ '{1,-1,-1,-1}, '{1,-1,-1,1}, '{1,-1,1,-1}, '{1,-1,1,1},
       '{1,1,1,-1}, '{1,1,1,1}, '{1,1,-1,-1}, '{1,1,-1,1} },
    '{ '{1,0,-1,-1}, '{1,-1,0,1}, '{1,1,0,-1}, '{1,0,1,1},
       '{0,0,0,0}, '{0,0,0,0}, '{0,0,0,0}, '{0,0,0,0} },
    '{ '{1,0,-1,-1}, '{1,-1,-1,1}, '{1,-1,1,-1}, '{1,0,1,1},
       '{1,1,1,-1}, '{1,1,-1,1}, '{0,0,0,0}, '{0,0,0,0} },
    '{ '{1,0,-1,-1}, '{1,-1,-1,1}, '{1,-1,0,-1}, '{1,-1,1,1},
       '{1,0,1,-1}, '{1,1,1,1}, '{1,1,0,-1}, '{1,1,-1,1} },
    '{ '{1,-1,0,0}, '{1,-1,0,0}, '{1,1,0,0}, '{1,1,0,0},
       '{0,0,-1,1}, '{0,0,1,1}, '{0,0,0,0}, '{0,0,0,0} }
  };

  // mixer state as the checker sees it
  logic [1:0]         cur_frame = FRAME_X;
  logic [3:0]         cur_count = 4'd4;
  logic [63:0]        cur_idle_low = '0;
  logic [63:0]        cur_idle_high = '0;
  logic signed [15:0] held_refs [8];

  cmd_item_t pending_cmds [$];
  mix_item_t mixes_expected [$];

  logic cmd_taken = 1'b0;
  logic mix_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   cmd_gap_max = 0;
  int   mix_stall_max = 0;
  int   cmd_wait = 0;
  int   mix_hold = 0;
  int   cmds_queued = 0;
  int   cmds_accepted = 0;
  int   unsupported_count = 0;
  int   clip_count = 0;
  int   setting_count = 0;
  int   quiet_cycles = 0;
  int   errors = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // expected references for one command item; updates the held values
  function automatic mix_item_t mix_predict(input cmd_item_t c);
    logic signed [15:0] refs [8];
    logic signed [15:0] idle;
    longint             scaled_thrust, factor, acc, level;
    int                 tbl, rows, base, k;
    logic               mixed;
    tbl = -1;
    rows = 0;
    base = 0;
    if (cur_frame == FRAME_TILT) begin
      tbl = int'(TBL_TILT);
      rows = 6;
    end else if (cur_frame == FRAME_X || cur_frame == FRAME_PLUS) begin
      base = (cur_frame == FRAME_X) ? int'(TBL_X4) : int'(TBL_PLUS4);
      case (cur_count)
        4'd4: begin
          tbl = base;
          rows = 4;
        end
        4'd6: begin
          tbl = base + 1;
          rows = 6;
        end
        4'd8: begin
          tbl = base + 2;
          rows = 8;
        end
        default: tbl = -1;
      endcase
    end
    if (rows > OUTPUTS) tbl = -1;
    mixed = (tbl >= 0);
    if (mixed) begin
      factor = c.landing ? longint'(c.landing_factor) : CMD_SCALE;
      scaled_thrust = longint'(c.thrust) * factor;
      for (k = 0; k < rows; k++) begin
        idle = (k < 4) ? cur_idle_low[16*k +: 16] : cur_idle_high[16*(k-4) +: 16];
        acc = scaled_thrust * mix_signs[tbl][k][0]
            + longint'(c.roll_cmd) * CMD_SCALE * mix_signs[tbl][k][1]
            + longint'(c.pitch_cmd) * CMD_SCALE * mix_signs[tbl][k][2]
            + longint'(c.yaw_cmd) * CMD_SCALE * mix_signs[tbl][k][3]
            + longint'(idle) * SUM_SCALE;
        // division truncates toward zero, then clip to 16 bits
        level = acc / SUM_SCALE;
        if (level > 32767) begin
          level = 32767;
          clip_count++;
        end else if (level < -32768) begin
          level = -32768;
          clip_count++;
        end
        held_refs[k] = level[15:0];
      end
    end else begin
      unsupported_count++;
    end
    for (k = 0; k < 8; k++) refs[k] = (k < OUTPUTS) ? held_refs[k] : 16'sd0;
    return {refs[0], refs[1], refs[2], refs[3], refs[4], refs[5], refs[6], refs[7], mixed};
  endfunction

  // handshake bookkeeping, register model, result checking and watchdog
  always @(posedge clk) begin : mix_check
    mix_item_t          want;
    logic signed [15:0] want_refs [8];
    logic signed [15:0] got_refs [8];
    logic               want_ok, got_ok;
    int                 k;
    cmd_taken <= cmd_valid && cmd_ready;
    mix_taken <= mix_valid && mix_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst) begin
      cur_frame = FRAME_X;
      cur_count = 4'd4;
      cur_idle_low = '0;
      cur_idle_high = '0;
      for (k = 0; k < 8; k++) held_refs[k] = '0;
      quiet_cycles = 0;
    end else begin
      if ((cmd_valid && cmd_ready) || (mix_valid && mix_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_TYPE:  cur_frame = cfg_data[1:0];
          REG_MOTOR_COUNT: cur_count = cfg_data[3:0];
          REG_IDLE_LOW:    cur_idle_low = cfg_data;
          REG_IDLE_HIGH:   cur_idle_high = cfg_data;
          default: ;
        endcase
      end
      // compare a finished item against the oldest expectation
      if (mix_valid && mix_ready) begin
        if (mixes_expected.size() == 0) begin
          errors++;
          $error("result item with no command item outstanding");
        end else begin
          want = mixes_expected.pop_front();
          {want_refs[0], want_refs[1], want_refs[2], want_refs[3], want_refs[4],
           want_refs[5], want_refs[6], want_refs[7], want_ok} = want;
          {got_refs[0], got_refs[1], got_refs[2], got_refs[3], got_refs[4],
           got_refs[5], got_refs[6], got_refs[7], got_ok} = mix;
          for (k = 0; k < 8; k++) begin
            if (got_refs[k] !== want_refs[k]) begin
              errors++;
              // keep the log short on a broken build
              if (errors <= REPORT_CAP)
                $error("ref%0d: expected %0d, actual %0d", k, want_refs[k], got_refs[k]);
            end
          end
          if (got_ok !== want_ok) begin
            errors++;
            if (errors <= REPORT_CAP)
              $error("valid_res: expected %0d, actual %0d", want_ok, got_ok);
          end
        end
      end
      // predict each accepted command item
      if (cmd_valid && cmd_ready) begin
        mixes_expected.push_back(mix_predict(cmd));
        cmds_accepted++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // command driver: one item at a time from the pending queue, random gaps
  always @(negedge clk) begin
    if (!rst && (!cmd_valid || cmd_taken)) begin
      if (cmd_wait != 0) begin
        cmd_valid <= 1'b0;
        cmd_wait--;
      end else if (pending_cmds.size() != 0) begin
        cmd <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
        cmd_wait = (cmd_gap_max == 0) ? 0 : $urandom_range(0, cmd_gap_max);
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, drawn per accepted item
  always @(negedge clk) begin
    if (!rst) begin
      if (mix_taken) mix_hold = (mix_stall_max == 0) ? 0 : $urandom_range(0, mix_stall_max);
      if (mix_hold != 0) begin
        mix_ready <= 1'b0;
        mix_hold--;
      end else begin
        mix_ready <= 1'b1;
      end
    end
  end

  function automatic cmd_item_t make_cmd(input int t, input int r, input int p, input int y,
                                         input bit land, input int fac);
    cmd_item_t c;
    c.thrust = t[15:0];
    c.roll_cmd = r[15:0];
    c.pitch_cmd = p[15:0];
    c.yaw_cmd = y[15:0];
    c.landing = land;
    c.landing_factor = fac[15:0];
    return c;
  endfunction

  function automatic logic [15:0] rand_cmd_word();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4, 5, 6, 7: return 16'($urandom_range(0, 8191)) - 16'd4096;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic cmd_item_t rand_cmd();
    cmd_item_t c;
    c.thrust = rand_cmd_word();
    c.roll_cmd = rand_cmd_word();
    c.pitch_cmd = rand_cmd_word();
    c.yaw_cmd = rand_cmd_word();
    c.landing = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: c.landing_factor = 16'd0;
      1: c.landing_factor = 16'd32768;
      2: c.landing_factor = 16'hFFFF;
      3, 4, 5: c.landing_factor = 16'($urandom_range(0, 32768));
      default: c.landing_factor = 16'($urandom());
    endcase
    return c;
  endfunction

  function automatic logic [63:0] rand_idle_word();
    logic [63:0] w;
    int          k;
    for (k = 0; k < 4; k++) begin
      case ($urandom_range(0, 7))
        0: w[16*k +: 16] = 16'h0000;
        1: w[16*k +: 16] = 16'h7FFF;
        2: w[16*k +: 16] = 16'h8000;
        3, 4, 5: w[16*k +: 16] = 16'($urandom_range(0, 2047));
        default: w[16*k +: 16] = 16'($urandom());
      endcase
    end
    return w;
  endfunction

  function automatic int rand_gap_max();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      default: return 16;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // writes the registers picked by sel, then lines up with a rising edge
  task automatic write_setting(input logic [1:0] frame, input logic [3:0] count,
                               input logic [63:0] idle_lo, input logic [63:0] idle_hi,
                               input logic [3:0] sel);
    if (sel[0]) write_reg(REG_FRAME_TYPE, 64'(frame));
    if (sel[1]) write_reg(REG_MOTOR_COUNT, 64'(count));
    if (sel[2]) write_reg(REG_IDLE_LOW, idle_lo);
    if (sel[3]) write_reg(REG_IDLE_HIGH, idle_hi);
    setting_count++;
    @(posedge clk);
  endtask

  // called just after a rising edge, so the driver never races the push
  task automatic queue_cmd(input cmd_item_t c);
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic wait_drain();
    while (cmds_accepted != cmds_queued || mixes_expected.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic directed_layout(input logic [1:0] frame, input logic [3:0] count,
                                 input logic [63:0] idle_lo, input logic [63:0] idle_hi);
    write_setting(frame, count, idle_lo, idle_hi, 4'hF);
    queue_cmd(make_cmd(800, -35, 50, -19, 1'b1, 20000));
    queue_cmd(make_cmd(32767, -32768, 32767, -32768, 1'b0, 0));
    wait_drain();
  endtask

  // reset, directed items, then random register settings and traffic
  initial begin
    int random_sent;
    int n;
    int i;
    logic [1:0] frame;
    logic [3:0] count;
    random_sent = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: X frame, four motors, no idle offset
    queue_cmd(make_cmd(0, 0, 0, 0, 1'b0, 0));
    queue_cmd(make_cmd(32767, 0, 0, 0, 1'b0, 0));
    queue_cmd(make_cmd(-32768, 0, 0, 0, 1'b0, 0));
    queue_cmd(make_cmd(0, 32767, -32768, 32767, 1'b0, 0));
    queue_cmd(make_cmd(-32768, -32768, -32768, -32768, 1'b1, 65535));
    queue_cmd(make_cmd(32767, 32767, 32767, 32767, 1'b1, 65535));
    // fractions truncate toward zero on both sides
    queue_cmd(make_cmd(-1, 0, 0, 0, 1'b0, 0));
    queue_cmd(make_cmd(17, -1, -33, 15, 1'b0, 0));
    queue_cmd(make_cmd(-33, 0, 0, 0, 1'b1, 16384));
    // landing factor of zero, of one, and ignored when not landing
    queue_cmd(make_cmd(32767, 0, 0, 0, 1'b1, 0));
    queue_cmd(make_cmd(1000, 0, 0, 0, 1'b1, 32768));
    queue_cmd(make_cmd(1600, 0, 0, 0, 1'b0, 65535));
    wait_drain();

    // every layout but the default X4 once, idle offsets at their extremes, unsupported settings
    cmd_gap_max = 2;
    mix_stall_max = 2;
    directed_layout(FRAME_X, 4'd6, {4{16'h7FFF}}, {4{16'h8000}});
    directed_layout(FRAME_X, 4'd8, {4{16'd1000}}, {4{16'd1000}});
    directed_layout(FRAME_PLUS, 4'd4, '0, '0);
    directed_layout(FRAME_PLUS, 4'd6, {4{16'h8000}}, {4{16'h7FFF}});
    directed_layout(FRAME_PLUS, 4'd8, {4{16'hFC18}}, {4{16'h03E8}});
    // the tilt layout ignores the motor count
    directed_layout(FRAME_TILT, 4'd2, 64'h0001_FFFF_7FFF_8000, 64'h0000_0000_00C8_FF38);
    // nothing written: held values come back with valid_res low
    directed_layout(FRAME_X, 4'd5, '0, '0);
    directed_layout(FRAME_NONE, 4'd8, '0, '0);

    // random phases, mostly on supported layouts
    while (random_sent < RANDOM_ITEMS) begin
      cmd_gap_max = rand_gap_max();
      mix_stall_max = rand_gap_max();
      frame = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 2)) : FRAME_NONE;
      case ($urandom_range(0, 9))
        0, 1, 2: count = 4'd4;
        3, 4, 5: count = 4'd6;
        6, 7: count = 4'd8;
        default: count = 4'($urandom_range(0, 15));
      endcase
      write_setting(frame, count, rand_idle_word(), rand_idle_word(),
                    (random_sent == 0) ? 4'hF : 4'($urandom_range(1, 15)));
      n = $urandom_range(10, 150);
      for (i = 0; i < n; i++) queue_cmd(rand_cmd());
      random_sent += n;
      wait_drain();
    end

    repeat (SETTLE) @(negedge clk);
    if (mixes_expected.size() != 0) begin
      errors++;
      $error("%0d result items never arrived", mixes_expected.size());
    end
    $display("checked %0d command items over %0d register settings, %0d on unsupported layouts",
             cmds_accepted, setting_count, unsupported_count);
    $display("%0d output references clipped to the 16-bit range", clip_count);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
